/* hdl/cbh_pkg.sv */
// Package for the base-38 callsign hash block.
// Holds the constants, the controller/datapath interface structs and the character decoder.
// No dependencies.
`default_nettype none

package cbh_pkg;

  localparam int unsigned CALL_LEN = 11;
  localparam int unsigned POS_W = 4;
  localparam int unsigned PACK_W = 58;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CFG_W = 6;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned MUL_W = 32;

  localparam logic [POS_W-1:0] CALL_LEN_C = POS_W'(CALL_LEN);
  localparam logic [35:0] HASH_MUL = 36'd47055833459;
  localparam logic [MUL_W-1:0] HASH_MUL_LO = HASH_MUL[31:0];
  localparam logic [MUL_W-1:0] HASH_MUL_HI = {28'd0, HASH_MUL[35:32]};
  localparam logic [CFG_W-1:0] HASH_BITS_RESET = 6'd22;
  localparam logic [CFG_W-1:0] HASH_BITS_MAX = 6'd32;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    MUL_LO_LO,
    MUL_HI_LO,
    MUL_LO_HI
  } mul_sel_t;

  typedef struct packed {
    logic     take_byte;
    logic     pad_step;
    logic     mul_step;
    mul_sel_t mul_sel;
    logic     load_out;
  } cbh_cmd_t;

  typedef struct packed {
    logic pos_full;
  } cbh_status_t;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] digit;
  } digit_t;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
    digit_t             r;
    logic [CHAR_W-1:0]  u;
    u = c;
    r.ok = 1'b1;
    r.digit = '0;
    if ((c >= 8'h61) && (c <= 8'h7A)) begin
      u = c - 8'h20;
    end
    if (u == CH_SPACE) begin
      r.digit = 6'd0;
    end else if ((u >= 8'h30) && (u <= 8'h39)) begin
      r.digit = DIGIT_W'(u - 8'h30 + 8'd1);
    end else if ((u >= 8'h41) && (u <= 8'h5A)) begin
      r.digit = DIGIT_W'(u - 8'h41 + 8'd11);
    end else if (u == 8'h2F) begin
      r.digit = 6'd37;
    end else if (u == 8'h40) begin
      r.digit = 6'd38;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/cbh_datapath.sv */
// Datapath of the callsign hash: base-38 accumulator, multiplier and output register.
// Driven by cbh_ctrl through cbh_pkg::cbh_cmd_t; uses cbh_pkg.
`default_nettype none

module cbh_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cbh_pkg::cbh_cmd_t            cmd,
  output cbh_pkg::cbh_status_t              status,
  input  wire logic                         cfg_we,
  input  wire logic [cbh_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic [cbh_pkg::CHAR_W-1:0]   char_byte,
  output logic      [cbh_pkg::HASH_W-1:0]   hash_value,
  output logic                              rejected
);
  import cbh_pkg::*;

  logic [CFG_W-1:0]  hash_bits_r;
  logic [PACK_W-1:0] packed_r, packed_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              started_r, started_nxt;
  logic              pend_r, pend_nxt;
  logic              inv_r, inv_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [HASH_W-1:0] hash_r;
  logic              rej_r;

  logic [PACK_W-1:0] packed_x38;
  logic              ws;
  logic              room;
  digit_t            dg;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [6:0]        shamt;
  logic [PROD_W-1:0] shifted;
  logic              hash_ok;

  assign packed_x38 = (packed_r << 5) + (packed_r << 2) + (packed_r << 1);
  assign ws = is_ws(char_byte);
  assign room = (pos_r < CALL_LEN_C);
  assign dg = digit_of(char_byte);
  assign status.pos_full = !room;

  always_comb begin
    packed_nxt = packed_r;
    pos_nxt = pos_r;
    started_nxt = started_r;
    pend_nxt = pend_r;
    inv_nxt = inv_r;
    if (cmd.load_out) begin
      packed_nxt = '0;
      pos_nxt = '0;
      started_nxt = 1'b0;
      pend_nxt = 1'b0;
      inv_nxt = 1'b0;
    end else if (cmd.pad_step) begin
      packed_nxt = packed_x38;
      pos_nxt = pos_r + 1'b1;
    end else if (cmd.take_byte) begin
      if (ws) begin
        if (started_r && room) begin
          packed_nxt = packed_x38;
          pos_nxt = pos_r + 1'b1;
          if (char_byte != CH_SPACE) begin
            pend_nxt = 1'b1;
          end
        end
      end else begin
        if (started_r && pend_r) begin
          inv_nxt = 1'b1;
        end
        started_nxt = 1'b1;
        if (room) begin
          pos_nxt = pos_r + 1'b1;
          if (dg.ok) begin
            packed_nxt = packed_x38 + PACK_W'(dg.digit);
          end else begin
            packed_nxt = packed_x38;
            inv_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    mul_a = packed_r[31:0];
    mul_b = HASH_MUL_LO;
    case (cmd.mul_sel)
      MUL_HI_LO: begin
        mul_a = MUL_W'(packed_r[PACK_W-1:32]);
        mul_b = HASH_MUL_LO;
      end
      MUL_LO_HI: begin
        mul_a = packed_r[31:0];
        mul_b = HASH_MUL_HI;
      end
      default: begin
        mul_a = packed_r[31:0];
        mul_b = HASH_MUL_LO;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.mul_step) begin
      if (cmd.mul_sel == MUL_LO_LO) begin
        acc_nxt = prod;
      end else begin
        acc_nxt = acc_r + {prod[31:0], 32'd0};
      end
    end
  end

  assign shamt = 7'd64 - {1'b0, hash_bits_r};
  assign shifted = acc_r >> shamt;
  assign hash_ok = !inv_r && (hash_bits_r != '0) && (hash_bits_r <= HASH_BITS_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_bits_r <= HASH_BITS_RESET;
      packed_r <= '0;
      pos_r <= '0;
      started_r <= 1'b0;
      pend_r <= 1'b0;
      inv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        hash_bits_r <= cfg_data;
      end
      packed_r <= packed_nxt;
      pos_r <= pos_nxt;
      started_r <= started_nxt;
      pend_r <= pend_nxt;
      inv_r <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.load_out) begin
      hash_r <= hash_ok ? shifted[HASH_W-1:0] : '0;
      rej_r <= inv_r;
    end
  end

  assign hash_value = hash_r;
  assign rejected = rej_r;

endmodule

`default_nettype wire

/* hdl/cbh_ctrl.sv */
// Controller of the callsign hash: sequences byte intake, padding, the multiply steps
// and the output handshake. Uses cbh_pkg.
`default_nettype none

module cbh_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_last_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire cbh_pkg::cbh_status_t status,
  output cbh_pkg::cbh_cmd_t         cmd
);
  import cbh_pkg::*;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_PAD,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;
  logic   out_free;

  assign take = in_valid && !in_stall_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    in_stall_nxt = in_stall_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '0;
    cmd.mul_sel = MUL_LO_LO;
    unique case (state_r)
      ST_ACC: begin
        if (take) begin
          cmd.take_byte = 1'b1;
          if (in_last_byte) begin
            state_nxt = ST_PAD;
            in_stall_nxt = 1'b1;
          end
        end
      end
      ST_PAD: begin
        if (status.pos_full) begin
          state_nxt = ST_MUL0;
        end else begin
          cmd.pad_step = 1'b1;
        end
      end
      ST_MUL0: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel = MUL_LO_LO;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel = MUL_HI_LO;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel = MUL_LO_HI;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          in_stall_nxt = 1'b0;
          state_nxt = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      in_stall_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      in_stall_r <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hdl/callsign_base38_hash_top.sv */
// Callsign base-38 hash, top level: joins the controller and the datapath.
// Uses cbh_pkg, cbh_ctrl and cbh_datapath.
//
// Usage: the input channel (in_valid, in_stall) carries one callsign byte per
// transaction, with in_last_byte set on the final byte of a string; a new byte
// is taken each time in_valid is high and in_stall is low. After the final byte
// the input stalls while the value is padded to 11 digits (one step per missing
// digit, until the value is found full) and multiplied in states ST_MUL0,
// ST_MUL1 and ST_MUL2 on a shared 32 by 32 multiplier; ST_LOAD then loads the
// result into the output register once that register is free.
// The output channel (out_valid, out_stall) carries one transaction per string.
// The result sits in an output register, so the next string's bytes are taken
// while it waits; a stalled receiver blocks only the next string's completion.
// The configuration channel (cfg_valid, cfg_ready) writes the hash width and is
// always ready. Reset sets the width to 22, clears the string state and
// drops out_valid.
`default_nettype none

module callsign_base38_hash_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [cbh_pkg::CHAR_W-1:0]   in_char_byte,
  input  wire logic                         in_last_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [cbh_pkg::HASH_W-1:0]   out_hash_value,
  output logic                              out_rejected,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cbh_pkg::CFG_W-1:0]    cfg_hash_bits
);
  import cbh_pkg::*;

  cbh_cmd_t    cmd;
  cbh_status_t status;

  assign cfg_ready = 1'b1;

  cbh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .cmd          (cmd)
  );

  cbh_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_hash_bits),
    .char_byte  (in_char_byte),
    .hash_value (out_hash_value),
    .rejected   (out_rejected)
  );

endmodule

`default_nettype wire
